FILE: rtl/core/lsps_pkg.sv
package lsps_pkg;

  // Default tick period in milliseconds.
  localparam int unsigned TICK_MS_DEFAULT = 20;

  localparam int unsigned PHASE_W = 11;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned COUNT_W = 32;

  localparam logic [LEVEL_W-1:0] FULL = 8'hFF;

  localparam logic               SLEEP_ENABLE_RESET = 1'b1;
  localparam logic [COUNT_W-1:0] SLEEP_TICKS_RESET  = 32'd90000;

  // Item opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SLEEP_ENABLE = 1'b0;
  localparam logic CFG_SLEEP_TICKS  = 1'b1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_INIT      = 4'd0;
  localparam logic [MODE_W-1:0] MODE_OFF       = 4'd1;
  localparam logic [MODE_W-1:0] MODE_BUILDING  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SUCCESS   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_UNSTABLE  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_FAILED    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_PREPARE   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_NIGHT     = 4'd7;
  localparam logic [MODE_W-1:0] MODE_WAIT      = 4'd8;
  localparam logic [MODE_W-1:0] MODE_ALTERNATE = 4'd9;
  localparam logic [MODE_W-1:0] MODE_ROLLING   = 4'd10;
  localparam logic [MODE_W-1:0] MODE_CYCLE     = 4'd11;

  // Architectural state of the sequencer. rem tracks phase modulo the
  // half-second ramp length while the power-on animation runs.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] rem;
    logic [COUNT_W-1:0] countdown;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] yellow;
    logic [LEVEL_W-1:0] green;
  } lamp_state_t;

endpackage

FILE: rtl/core/lsps_ramp.sv
// 255 * num / D, clamped to 255, with D = ticks per half second.
// The constant divide is a multiply by a rounded-up reciprocal, exact for
// every 19-bit dividend.
module lsps_ramp #(
  parameter int unsigned TICK_MS = lsps_pkg::TICK_MS_DEFAULT
) (
  input  logic [lsps_pkg::PHASE_W-1:0] num,
  output logic [lsps_pkg::LEVEL_W-1:0] level
);

  localparam int unsigned X_W   = lsps_pkg::PHASE_W + lsps_pkg::LEVEL_W;
  localparam int unsigned DIV   = 500 / TICK_MS;
  localparam int unsigned SHIFT = X_W + $clog2(DIV);
  localparam longint unsigned RECIP =
    ((longint'(1) << SHIFT) + longint'(DIV) - 1) / longint'(DIV);
  localparam logic [X_W:0] RECIP_C = (X_W+1)'(RECIP);

  logic [X_W-1:0]   scaled;
  logic [2*X_W:0]   prod;
  logic [2*X_W:0]   quot;

  assign scaled = {num, {lsps_pkg::LEVEL_W{1'b0}}} - X_W'(num);
  assign prod   = (2*X_W+1)'(scaled) * (2*X_W+1)'(RECIP_C);
  assign quot   = prod >> SHIFT;
  assign level  = (quot > (2*X_W+1)'(lsps_pkg::FULL)) ? lsps_pkg::FULL
                                                      : quot[lsps_pkg::LEVEL_W-1:0];

endmodule

FILE: rtl/core/lsps_step.sv
// Next-state and result logic for one item.
module lsps_step #(
  parameter int unsigned TICK_MS = lsps_pkg::TICK_MS_DEFAULT
) (
  input  lsps_pkg::lamp_state_t               cur,
  input  logic                                op,
  input  logic [lsps_pkg::MODE_W-1:0]         requested_mode,
  input  logic                                sleep_enable,
  input  logic [lsps_pkg::COUNT_W-1:0]        sleep_ticks,
  output lsps_pkg::lamp_state_t               nxt,
  output logic                                accepted
);

  localparam logic [31:0] T500   = 32'(500 / TICK_MS);
  localparam logic [31:0] T750   = 32'(750 / TICK_MS);
  localparam logic [31:0] T1000  = 32'(1000 / TICK_MS);
  localparam logic [31:0] T1250  = 32'(1250 / TICK_MS);
  localparam logic [31:0] T1500  = 32'(1500 / TICK_MS);
  localparam logic [31:0] T2000  = 32'(2000 / TICK_MS);
  localparam logic [31:0] T3000  = 32'(3000 / TICK_MS);
  localparam logic [31:0] T3500  = 32'(3500 / TICK_MS);
  localparam logic [31:0] T4000  = 32'(4000 / TICK_MS);
  localparam logic [31:0] T4500  = 32'(4500 / TICK_MS);
  localparam logic [31:0] T10000 = 32'(10000 / TICK_MS);
  localparam logic [31:0] T11000 = 32'(11000 / TICK_MS);
  localparam logic [31:0] T21000 = 32'(21000 / TICK_MS);
  localparam logic [31:0] T23000 = 32'(23000 / TICK_MS);

  localparam int unsigned PW = lsps_pkg::PHASE_W;

  logic [31:0]                    pw;
  logic [PW-1:0]                  ramp_num;
  logic [lsps_pkg::LEVEL_W-1:0]   ramp_level;
  logic [lsps_pkg::LEVEL_W-1:0]   ramp_inv;
  logic [lsps_pkg::COUNT_W-1:0]   count;
  logic                           init_done;

  // phase + 1 modulo period; phase always stays below period in these modes
  function automatic logic [PW-1:0] wrap_next(input logic [31:0] phase,
                                              input logic [31:0] period);
    logic [31:0] inc;
    inc = phase + 32'd1;
    if (inc >= period) begin
      inc = inc - period;
    end
    return inc[PW-1:0];
  endfunction

  assign pw = 32'(cur.phase);

  // One ramp unit serves every mode; pick its position in the current segment.
  always_comb begin
    case (cur.mode)
      lsps_pkg::MODE_INIT: begin
        ramp_num = cur.rem;
      end
      lsps_pkg::MODE_BUILDING: begin
        ramp_num = (pw < T500) ? cur.phase : PW'(pw - T750);
      end
      lsps_pkg::MODE_ROLLING: begin
        if (pw < T500) begin
          ramp_num = cur.phase;
        end else if (pw < T1000) begin
          ramp_num = PW'(pw - T500);
        end else if (pw < T1500) begin
          ramp_num = PW'(pw - T1000);
        end else begin
          ramp_num = PW'(pw - T1500);
        end
      end
      default: begin
        ramp_num = '0;
      end
    endcase
  end

  lsps_ramp #(.TICK_MS(TICK_MS)) u_ramp (
    .num   (ramp_num),
    .level (ramp_level)
  );

  assign ramp_inv = lsps_pkg::FULL - ramp_level;

  always_comb begin
    nxt       = cur;
    accepted  = 1'b0;
    init_done = 1'b0;
    count     = cur.countdown;
    if (op == lsps_pkg::OP_TICK) begin
      case (cur.mode)
        lsps_pkg::MODE_INIT: begin
          if (pw < T500) begin
            {nxt.red, nxt.yellow, nxt.green} = {ramp_level, 8'd0, 8'd0};
          end else if (pw < T1000) begin
            {nxt.red, nxt.yellow, nxt.green} = {lsps_pkg::FULL, ramp_level, 8'd0};
          end else if (pw < T1500) begin
            {nxt.red, nxt.yellow, nxt.green} = {lsps_pkg::FULL, lsps_pkg::FULL, ramp_level};
          end else if (pw < T3000) begin
            {nxt.red, nxt.yellow, nxt.green} = {3{lsps_pkg::FULL}};
          end else if (pw < T3500) begin
            {nxt.red, nxt.yellow, nxt.green} = {ramp_inv, lsps_pkg::FULL, lsps_pkg::FULL};
          end else if (pw < T4000) begin
            {nxt.red, nxt.yellow, nxt.green} = {8'd0, ramp_inv, lsps_pkg::FULL};
          end else if (pw < T4500) begin
            {nxt.red, nxt.yellow, nxt.green} = {8'd0, 8'd0, ramp_inv};
          end else begin
            init_done = 1'b1;
            nxt.mode  = lsps_pkg::MODE_OFF;
          end
          nxt.phase = cur.phase + PW'(1);
          // keep rem equal to phase mod ramp length, including the phase wrap
          if (cur.phase == {PW{1'b1}}) begin
            nxt.rem = '0;
          end else if (32'(cur.rem) + 32'd1 == T500) begin
            nxt.rem = '0;
          end else begin
            nxt.rem = cur.rem + PW'(1);
          end
        end
        lsps_pkg::MODE_OFF: begin
          {nxt.red, nxt.yellow, nxt.green} = '0;
        end
        lsps_pkg::MODE_BUILDING: begin
          if (pw < T500) begin
            {nxt.red, nxt.yellow, nxt.green} = {8'd0, ramp_level, 8'd0};
          end else if (pw < T750) begin
            {nxt.red, nxt.yellow, nxt.green} = {8'd0, lsps_pkg::FULL, 8'd0};
          end else if (pw < T1250) begin
            {nxt.red, nxt.yellow, nxt.green} = {8'd0, ramp_inv, 8'd0};
          end else begin
            {nxt.red, nxt.yellow, nxt.green} = '0;
          end
          nxt.phase = wrap_next(pw, T1500);
        end
        lsps_pkg::MODE_SUCCESS: begin
          {nxt.red, nxt.yellow, nxt.green} = {8'd0, 8'd0, lsps_pkg::FULL};
        end
        lsps_pkg::MODE_UNSTABLE: begin
          {nxt.red, nxt.yellow, nxt.green} = {8'd0, lsps_pkg::FULL, 8'd0};
        end
        lsps_pkg::MODE_FAILED: begin
          {nxt.red, nxt.yellow, nxt.green} = {lsps_pkg::FULL, 8'd0, 8'd0};
        end
        lsps_pkg::MODE_PREPARE: begin
          {nxt.red, nxt.yellow, nxt.green} = {lsps_pkg::FULL, lsps_pkg::FULL, 8'd0};
        end
        lsps_pkg::MODE_NIGHT: begin
          nxt.red    = 8'd0;
          nxt.yellow = (pw < T1000) ? lsps_pkg::FULL : 8'd0;
          nxt.green  = 8'd0;
          nxt.phase  = wrap_next(pw, T2000);
        end
        lsps_pkg::MODE_WAIT: begin
          nxt.red    = (pw < T500) ? lsps_pkg::FULL : 8'd0;
          nxt.yellow = 8'd0;
          nxt.green  = (pw < T500) ? lsps_pkg::FULL : 8'd0;
          nxt.phase  = wrap_next(pw, T1000);
        end
        lsps_pkg::MODE_ALTERNATE: begin
          if (pw < T1000) begin
            {nxt.red, nxt.yellow, nxt.green} = {lsps_pkg::FULL, 8'd0, lsps_pkg::FULL};
          end else begin
            {nxt.red, nxt.yellow, nxt.green} = {8'd0, lsps_pkg::FULL, 8'd0};
          end
          nxt.phase = wrap_next(pw, T2000);
        end
        lsps_pkg::MODE_ROLLING: begin
          if (pw < T500) begin
            {nxt.red, nxt.yellow, nxt.green} = {ramp_level, 8'd0, 8'd0};
          end else if (pw < T1000) begin
            {nxt.red, nxt.yellow, nxt.green} = {ramp_inv, ramp_level, 8'd0};
          end else if (pw < T1500) begin
            {nxt.red, nxt.yellow, nxt.green} = {8'd0, ramp_inv, ramp_level};
          end else if (pw < T2000) begin
            {nxt.red, nxt.yellow, nxt.green} = {8'd0, 8'd0, ramp_inv};
          end else begin
            {nxt.red, nxt.yellow, nxt.green} = '0;
          end
          nxt.phase = wrap_next(pw, T3000);
        end
        lsps_pkg::MODE_CYCLE: begin
          // red, red+yellow, green, yellow; untouched lamps hold
          if (pw < T10000) begin
            {nxt.red, nxt.yellow, nxt.green} = {lsps_pkg::FULL, 8'd0, 8'd0};
          end else if (pw < T11000) begin
            nxt.yellow = lsps_pkg::FULL;
          end else if (pw < T21000) begin
            {nxt.red, nxt.yellow, nxt.green} = {8'd0, 8'd0, lsps_pkg::FULL};
          end else begin
            nxt.yellow = lsps_pkg::FULL;
            nxt.green  = 8'd0;
          end
          nxt.phase = wrap_next(pw, T23000);
        end
        default: begin
          nxt.mode = lsps_pkg::MODE_INIT;
        end
      endcase

      // inactivity countdown, after the mode step
      if (init_done) begin
        count = '0;
      end
      if (count != '0) begin
        count = count - lsps_pkg::COUNT_W'(1);
      end
      if (count == '0) begin
        if (sleep_enable) begin
          nxt.mode = lsps_pkg::MODE_OFF;
        end else begin
          count = sleep_ticks;
        end
      end
      nxt.countdown = count;
    end else begin
      if (requested_mode <= lsps_pkg::MODE_CYCLE) begin
        accepted      = 1'b1;
        nxt.countdown = sleep_ticks;
        if (requested_mode != cur.mode) begin
          nxt.mode  = requested_mode;
          nxt.phase = '0;
          nxt.rem   = '0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/led_signal_pattern_sequencer.sv
// Red/yellow/green lamp sequencer. Each request on the item channel is either
// a tick (op = 0), which steps the current mode's animation and updates the
// three 8-bit lamp levels, or a mode request (op = 1) for codes 0..11; codes
// 12..15 are rejected with accepted = 0 and change nothing. Every request
// yields exactly one result carrying the lamp levels, accepted and the mode.
// The block takes one request per clock while result_stall stays low: a
// request is registered in the input register, the next-state logic (one
// constant-reciprocal multiply for the fade ramps plus the 32-bit sleep
// countdown) runs from that register, and the result lands in the output
// register. item_stall rises only when the output register is held and the
// input register is full. After rst the mode is the power-on ramp, the lamps
// are off and the countdown holds 90000. Configuration (index 0 sleep_enable,
// index 1 sleep_ticks) is always ready and should be written while idle.
module led_signal_pattern_sequencer #(
  parameter int unsigned TICK_MS = lsps_pkg::TICK_MS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                op,
  input  logic [lsps_pkg::MODE_W-1:0]         requested_mode,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [lsps_pkg::LEVEL_W-1:0]        red_level,
  output logic [lsps_pkg::LEVEL_W-1:0]        yellow_level,
  output logic [lsps_pkg::LEVEL_W-1:0]        green_level,
  output logic                                accepted,
  output logic [lsps_pkg::MODE_W-1:0]         current_mode,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [lsps_pkg::COUNT_W-1:0]        cfg_data
);

  // configuration registers
  logic                           sleep_enable;
  logic [lsps_pkg::COUNT_W-1:0]   sleep_ticks;

  // input register
  logic                           in_valid;
  logic                           in_op;
  logic [lsps_pkg::MODE_W-1:0]    in_mode;

  // architectural state and its next value
  lsps_pkg::lamp_state_t          state;
  lsps_pkg::lamp_state_t          state_next;
  logic                           accepted_next;

  logic                           out_en;
  logic                           in_load;

  // output stage advances unless a held result is stalled;
  // input register loads when it empties into the output stage or is empty
  assign out_en     = !result_valid || !result_stall;
  assign in_load    = out_en || !in_valid;
  assign item_stall = !in_load;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_enable <= lsps_pkg::SLEEP_ENABLE_RESET;
      sleep_ticks  <= lsps_pkg::SLEEP_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsps_pkg::CFG_SLEEP_ENABLE: sleep_enable <= cfg_data[0];
        lsps_pkg::CFG_SLEEP_TICKS:  sleep_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_op   <= op;
      in_mode <= requested_mode;
    end
  end

  lsps_step #(.TICK_MS(TICK_MS)) u_step (
    .cur            (state),
    .op             (in_op),
    .requested_mode (in_mode),
    .sleep_enable   (sleep_enable),
    .sleep_ticks    (sleep_ticks),
    .nxt            (state_next),
    .accepted       (accepted_next)
  );

  // state commits together with the result it produces
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode      <= lsps_pkg::MODE_INIT;
      state.phase     <= '0;
      state.rem       <= '0;
      state.countdown <= lsps_pkg::SLEEP_TICKS_RESET;
      state.red       <= '0;
      state.yellow    <= '0;
      state.green     <= '0;
    end else if (out_en && in_valid) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && in_valid) begin
      red_level    <= state_next.red;
      yellow_level <= state_next.yellow;
      green_level  <= state_next.green;
      accepted     <= accepted_next;
      current_mode <= state_next.mode;
    end
  end

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall && in_valid))
    else $error("item_stall without a held result");

  // a buffered request always moves into the result register when it can
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_en) |=> result_valid)
    else $error("buffered request lost");

  // ticks never report an accepted mode request
  a_tick_not_accepted: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_en && (in_op == lsps_pkg::OP_TICK)) |=> !accepted)
    else $error("tick reported as accepted");

  // reported mode is always a defined code
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (current_mode <= lsps_pkg::MODE_CYCLE))
    else $error("undefined mode reported");

endmodule
